/* src/sqg_pkg.sv */
// Shared package for the single-qubit gate engine.
// Holds operation codes, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
package sqg_pkg;

    localparam logic [3:0] MODE_H       = 4'd0;
    localparam logic [3:0] MODE_X       = 4'd1;
    localparam logic [3:0] MODE_Y       = 4'd2;
    localparam logic [3:0] MODE_Z       = 4'd3;
    localparam logic [3:0] MODE_RX      = 4'd4;
    localparam logic [3:0] MODE_RY      = 4'd5;
    localparam logic [3:0] MODE_RZ      = 4'd6;
    localparam logic [3:0] MODE_AXIS    = 4'd7;
    localparam logic [3:0] MODE_MEASURE = 4'd8;
    localparam logic [3:0] MODE_LOAD    = 4'd9;

    localparam int CORDIC_MAX_STEPS = 24;
    localparam int UNIT_Q15         = 32768;
    localparam int INV_SQRT2_Q16    = 46341;
    localparam int CORDIC_GAIN_Q30  = 652032874;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                5'd0:    r = 32'h20000000;
                5'd1:    r = 32'h12E4051E;
                5'd2:    r = 32'h09FB385B;
                5'd3:    r = 32'h051111D4;
                5'd4:    r = 32'h028B0D43;
                5'd5:    r = 32'h0145D7E1;
                5'd6:    r = 32'h00A2F61E;
                5'd7:    r = 32'h00517C55;
                5'd8:    r = 32'h0028BE53;
                5'd9:    r = 32'h00145F2F;
                5'd10:   r = 32'h000A2F98;
                5'd11:   r = 32'h000517CC;
                5'd12:   r = 32'h00028BE6;
                5'd13:   r = 32'h000145F3;
                5'd14:   r = 32'h0000A2FA;
                5'd15:   r = 32'h0000517D;
                5'd16:   r = 32'h000028BE;
                5'd17:   r = 32'h0000145F;
                5'd18:   r = 32'h00000A30;
                5'd19:   r = 32'h00000518;
                5'd20:   r = 32'h0000028C;
                5'd21:   r = 32'h00000146;
                5'd22:   r = 32'h000000A3;
                5'd23:   r = 32'h00000051;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage

/* src/sqg_cordic.sv */
// Iterative rotation-mode CORDIC giving Q1.15 cosine and sine of a turn fraction.
// One micro-rotation per cycle through two variable shifters. Depends on sqg_pkg.
module sqg_cordic
#(
    parameter int STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [16:0] cos_q,
    output logic signed [16:0] sin_q
);
    import sqg_pkg::*;

    localparam int N = (STEPS < CORDIC_MAX_STEPS) ? STEPS : CORDIC_MAX_STEPS;

    logic signed [32:0] x_reg, y_reg, z_reg;
    logic signed [32:0] dx, dy, at;
    logic signed [16:0] cq, sq;
    logic [1:0]         quad_reg;
    logic [4:0]         i_reg;
    logic               busy_reg, done_reg;
    logic signed [16:0] cos_reg, sin_reg;

    function automatic logic signed [16:0] to_q15(input logic signed [32:0] v);
        logic signed [33:0] t;
        begin
            t = ($signed({v[32], v}) + 34'sd16384) >>> 15;
            if (t > 34'sd32768)
                t = 34'sd32768;
            else if (t < -34'sd32768)
                t = -34'sd32768;
            return t[16:0];
        end
    endfunction

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign at = $signed({1'b0, atan_turn(i_reg)});
    assign cq = to_q15(x_reg);
    assign sq = to_q15(y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
                x_reg    <= 33'(CORDIC_GAIN_Q30);
                y_reg    <= '0;
                z_reg    <= $signed({3'b000, angle[29:0]});
                quad_reg <= angle[31:30];
            end
            else if (busy_reg)
            begin
                if (i_reg == 5'(N))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    unique case (quad_reg)
                        2'd0:
                        begin
                            cos_reg <= cq;
                            sin_reg <= sq;
                        end
                        2'd1:
                        begin
                            cos_reg <= -sq;
                            sin_reg <= cq;
                        end
                        2'd2:
                        begin
                            cos_reg <= -cq;
                            sin_reg <= -sq;
                        end
                        default:
                        begin
                            cos_reg <= sq;
                            sin_reg <= -cq;
                        end
                    endcase
                end
                else
                begin
                    i_reg <= i_reg + 5'd1;
                    if (!z_reg[32])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + at;
                    end
                end
            end
        end
    end

    assign done  = done_reg;
    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

/* src/sqg_sqrt.sv */
// Bit-serial integer square root, one result bit per cycle.
// Returns floor(sqrt(radicand)). No dependencies.
module sqg_sqrt
#(
    parameter int HW = 33
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*HW-1:0] radicand,
    output logic            done,
    output logic [HW-1:0]   root
);
    logic [2*HW-1:0]         rad_reg;
    logic [HW+1:0]           rem_reg;
    logic [HW-1:0]           root_reg;
    logic [$clog2(HW+1)-1:0] cnt_reg;
    logic                    busy_reg, done_reg;
    logic [HW+1:0]           rem_s, trial;

    assign rem_s = {rem_reg[HW-1:0], rad_reg[2*HW-1:2*HW-2]};
    assign trial = {root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rad_reg <= {rad_reg[2*HW-3:0], 2'b00};
                if (rem_s >= trial)
                begin
                    rem_reg  <= rem_s - trial;
                    root_reg <= {root_reg[HW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_s;
                    root_reg <= {root_reg[HW-2:0], 1'b0};
                end
                if (cnt_reg == ($clog2(HW+1))'(HW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* src/sqg_div.sv */
// Restoring divider, one quotient bit per cycle, rounding half away from zero.
// Signed numerator, unsigned denominator. No dependencies.
module sqg_div
#(
    parameter int NDW = 47,
    parameter int DW  = 33
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [NDW-1:0] num,
    input  logic [DW-1:0]         den,
    output logic                  done,
    output logic signed [NDW:0]   quot
);
    logic [NDW-1:0]           dvd_reg, mag;
    logic [DW-1:0]            rem_reg, den_reg;
    logic [DW:0]              rem_s;
    logic                     neg_reg, busy_reg, done_reg;
    logic [$clog2(NDW+1)-1:0] cnt_reg;

    assign mag   = num[NDW-1] ? (~num + 1'b1) : num;
    assign rem_s = {rem_reg, dvd_reg[NDW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                neg_reg  <= num[NDW-1];
                dvd_reg  <= mag + NDW'(den >> 1);
                den_reg  <= den;
                rem_reg  <= '0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (rem_s >= {1'b0, den_reg})
                begin
                    rem_reg <= DW'(rem_s - {1'b0, den_reg});
                    dvd_reg <= {dvd_reg[NDW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_s[DW-1:0];
                    dvd_reg <= {dvd_reg[NDW-2:0], 1'b0};
                end
                if (cnt_reg == ($clog2(NDW+1))'(NDW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});

endmodule

/* src/single_qubit_gate_engine_top.sv */
// Single-qubit gate engine: sequencer around one shared multiply-accumulate unit.
// X, Z and read only compute the probabilities; measure first collapses the state. Y and
// load renormalise through sqg_sqrt and sqg_div, as do H and rotations after their products;
// axis rotate first normalises the axis. One transaction in flight; the next is
// accepted once the result register takes this one. Reset (rst_n, async low) returns the
// qubit to |0> and empties the output. Uses sqg_pkg, sqg_cordic, sqg_sqrt and sqg_div.
module single_qubit_gate_engine_top
#(
    parameter int AMP_WIDTH    = 18,
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         mode,
    input  logic [15:0]        half_angle,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic signed [15:0] load_zero_re,
    input  logic signed [15:0] load_zero_im,
    input  logic signed [15:0] load_one_re,
    input  logic signed [15:0] load_one_im,
    input  logic [15:0]        random_fraction,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] zero_re,
    output logic signed [15:0] zero_im,
    output logic signed [15:0] one_re,
    output logic signed [15:0] one_im,
    output logic [15:0]        zero_prob,
    output logic [15:0]        prob_one,
    output logic               measured_bit,
    output logic               measure_valid
);
    import sqg_pkg::*;

    localparam int A   = AMP_WIDTH;
    localparam int MW  = (A + 2 > 18) ? A + 2 : 18;
    localparam int AW  = 2 * MW + 2;
    localparam int N2W = 2 * MW;
    localparam int HW  = MW + 15;
    localparam int SW  = 2 * HW;
    localparam int NDW = (A + 28 > 47) ? A + 28 : 47;
    localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_WIDTH) - 64'd1);
    localparam int ASH = 32 - ANGLE_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_MUL, S_ACC, S_FIN, S_NORM_CHK, S_AX_CHK,
        S_SQRT, S_DIV, S_CORDIC, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        J_H, J_SN, J_ROT, J_N2, J_AX2, J_MEAS, J_PROB
    } job_t;

    state_t state_reg;
    job_t   job_reg;
    logic [1:0] grp_reg, term_reg, last_term, last_grp;

    logic [3:0]         mode_reg;
    logic [15:0]        half_angle_reg, rf_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;

    logic signed [A-1:0]  zr_reg, zi_reg, or_reg, oi_reg;
    logic signed [A-1:0]  v_reg [4];
    logic signed [MW-1:0] nx_reg, ny_reg, nz_reg, snx_reg, sny_reg, snz_reg;
    logic [N2W-1:0]       n2_reg;
    logic                 div_axis_reg;

    logic signed [MW-1:0]   ma, mb;
    logic signed [2*MW-1:0] prod_reg;
    logic signed [AW-1:0]   acc_reg;
    logic signed [AW:0]     acc_ext, r15, r16, r14;
    logic signed [A:0]      hsum;
    logic [15:0]            psat;

    logic                  sqrt_start_reg, sqrt_done;
    logic [SW-1:0]         sqrt_in;
    logic [HW-1:0]         root;
    logic                  div_start_reg, div_done;
    logic signed [NDW-1:0] div_num;
    logic signed [NDW:0]   quot;
    logic                  cordic_start_reg, cordic_done;
    logic signed [16:0]    cos_q, sin_q;
    logic [31:0]           angle_word;

    logic                  out_valid_reg, mbit_reg, mvalid_reg;
    logic signed [15:0]    zero_re_reg, zero_im_reg, one_re_reg, one_im_reg;
    logic [15:0]           p0_reg, p1_reg;

    function automatic logic signed [A-1:0] sat_amp(input logic signed [AW:0] x);
        logic signed [AW:0] hi;
        logic signed [AW:0] lo;
        begin
            hi = $signed({{(AW - A + 2){1'b0}}, {(A - 1){1'b1}}});
            lo = ~hi;
            if (x > hi)
                x = hi;
            else if (x < lo)
                x = lo;
            return x[A-1:0];
        end
    endfunction

    function automatic logic signed [A-1:0] sat_q(input logic signed [NDW:0] x);
        logic signed [NDW:0] hi;
        logic signed [NDW:0] lo;
        begin
            hi = $signed({{(NDW - A + 2){1'b0}}, {(A - 1){1'b1}}});
            lo = ~hi;
            if (x > hi)
                x = hi;
            else if (x < lo)
                x = lo;
            return x[A-1:0];
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [A-1:0] x);
        logic signed [39:0] w;
        begin
            w = 40'(x);
            if (w > 40'sd32767)
                w = 40'sd32767;
            else if (w < -40'sd32768)
                w = -40'sd32768;
            return w[15:0];
        end
    endfunction

    assign acc_ext = {acc_reg[AW-1], acc_reg};
    assign r14 = (acc_ext + $signed((AW+1)'(8192))) >>> 14;
    assign r15 = (acc_ext + $signed((AW+1)'(16384))) >>> 15;
    assign r16 = (acc_ext + $signed((AW+1)'(32768))) >>> 16;
    assign psat = (r14 > $signed((AW+1)'(65535))) ? 16'hFFFF : r14[15:0];

    always_comb
    begin
        unique case (grp_reg)
            2'd0:    hsum = (A+1)'(zr_reg) + (A+1)'(or_reg);
            2'd1:    hsum = (A+1)'(zi_reg) + (A+1)'(oi_reg);
            2'd2:    hsum = (A+1)'(zr_reg) - (A+1)'(or_reg);
            default: hsum = (A+1)'(zi_reg) - (A+1)'(oi_reg);
        endcase
    end

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (job_reg)
            J_H:
            begin
                ma = MW'(hsum);
                mb = MW'(INV_SQRT2_Q16);
            end
            J_SN:
            begin
                ma = MW'(sin_q);
                unique case (grp_reg)
                    2'd0:    mb = nx_reg;
                    2'd1:    mb = ny_reg;
                    default: mb = nz_reg;
                endcase
            end
            J_ROT:
            begin
                unique case ({grp_reg, term_reg})
                    4'h0: begin ma = MW'(cos_q); mb = MW'(zr_reg); end
                    4'h1: begin ma = snz_reg;    mb = MW'(zi_reg); end
                    4'h2: begin ma = -sny_reg;   mb = MW'(or_reg); end
                    4'h3: begin ma = snx_reg;    mb = MW'(oi_reg); end
                    4'h4: begin ma = MW'(cos_q); mb = MW'(zi_reg); end
                    4'h5: begin ma = -snz_reg;   mb = MW'(zr_reg); end
                    4'h6: begin ma = -sny_reg;   mb = MW'(oi_reg); end
                    4'h7: begin ma = -snx_reg;   mb = MW'(or_reg); end
                    4'h8: begin ma = sny_reg;    mb = MW'(zr_reg); end
                    4'h9: begin ma = snx_reg;    mb = MW'(zi_reg); end
                    4'hA: begin ma = MW'(cos_q); mb = MW'(or_reg); end
                    4'hB: begin ma = -snz_reg;   mb = MW'(oi_reg); end
                    4'hC: begin ma = sny_reg;    mb = MW'(zi_reg); end
                    4'hD: begin ma = -snx_reg;   mb = MW'(zr_reg); end
                    4'hE: begin ma = MW'(cos_q); mb = MW'(oi_reg); end
                    default: begin ma = snz_reg; mb = MW'(or_reg); end
                endcase
            end
            J_N2:
            begin
                ma = MW'(v_reg[term_reg]);
                mb = MW'(v_reg[term_reg]);
            end
            J_AX2:
            begin
                unique case (term_reg)
                    2'd0:    ma = MW'(ax_reg);
                    2'd1:    ma = MW'(ay_reg);
                    default: ma = MW'(az_reg);
                endcase
                mb = ma;
            end
            default:
            begin
                unique case ({grp_reg[0], term_reg[0]})
                    2'b00:   ma = MW'(zr_reg);
                    2'b01:   ma = MW'(zi_reg);
                    2'b10:   ma = MW'(or_reg);
                    default: ma = MW'(oi_reg);
                endcase
                mb = ma;
            end
        endcase
    end

    always_comb
    begin
        unique case (job_reg)
            J_H, J_SN: last_term = 2'd0;
            J_ROT, J_N2: last_term = 2'd3;
            J_AX2: last_term = 2'd2;
            default: last_term = 2'd1;
        endcase
        unique case (job_reg)
            J_H, J_ROT: last_grp = 2'd3;
            J_SN: last_grp = 2'd2;
            J_PROB: last_grp = 2'd1;
            default: last_grp = 2'd0;
        endcase
    end

    assign sqrt_in = div_axis_reg ? (SW'(n2_reg) << 30) : (SW'(n2_reg) << 24);

    always_comb
    begin
        if (div_axis_reg)
        begin
            unique case (grp_reg)
                2'd0:    div_num = NDW'(ax_reg) <<< 30;
                2'd1:    div_num = NDW'(ay_reg) <<< 30;
                default: div_num = NDW'(az_reg) <<< 30;
            endcase
        end
        else
        begin
            div_num = NDW'(v_reg[grp_reg]) <<< 27;
        end
    end

    assign angle_word = (32'(half_angle_reg) & AMASK) << ASH;

    sqg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start_reg),
        .angle (angle_word),
        .done  (cordic_done),
        .cos_q (cos_q),
        .sin_q (sin_q)
    );

    sqg_sqrt #(.HW(HW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (root)
    );

    sqg_div #(.NDW(NDW), .DW(HW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num),
        .den   (root),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            job_reg          <= J_PROB;
            grp_reg          <= '0;
            term_reg         <= '0;
            div_axis_reg     <= 1'b0;
            sqrt_start_reg   <= 1'b0;
            div_start_reg    <= 1'b0;
            cordic_start_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            zr_reg           <= A'(UNIT_Q15);
            zi_reg           <= '0;
            or_reg           <= '0;
            oi_reg           <= '0;
        end
        else
        begin
            sqrt_start_reg   <= 1'b0;
            div_start_reg    <= 1'b0;
            cordic_start_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg       <= mode;
                        half_angle_reg <= half_angle;
                        ax_reg         <= axis_x;
                        ay_reg         <= axis_y;
                        az_reg         <= axis_z;
                        rf_reg         <= random_fraction;
                        v_reg[0]       <= A'(load_zero_re);
                        v_reg[1]       <= A'(load_zero_im);
                        v_reg[2]       <= A'(load_one_re);
                        v_reg[3]       <= A'(load_one_im);
                        state_reg      <= S_DECODE;
                    end
                end

                S_DECODE:
                begin
                    mbit_reg   <= 1'b0;
                    mvalid_reg <= (mode_reg == MODE_MEASURE);
                    grp_reg    <= '0;
                    term_reg   <= '0;
                    acc_reg    <= '0;
                    state_reg  <= S_MUL;
                    job_reg    <= J_PROB;
                    nx_reg     <= '0;
                    ny_reg     <= '0;
                    nz_reg     <= MW'(UNIT_Q15);
                    unique case (mode_reg)
                        MODE_H: job_reg <= J_H;
                        MODE_X:
                        begin
                            zr_reg <= or_reg;
                            or_reg <= zr_reg;
                            zi_reg <= oi_reg;
                            oi_reg <= zi_reg;
                        end
                        MODE_Y:
                        begin
                            v_reg[0] <= oi_reg;
                            v_reg[1] <= sat_amp(-(AW+1)'(or_reg));
                            v_reg[2] <= sat_amp(-(AW+1)'(zi_reg));
                            v_reg[3] <= zr_reg;
                            job_reg  <= J_N2;
                        end
                        MODE_Z:
                        begin
                            or_reg <= sat_amp(-(AW+1)'(or_reg));
                            oi_reg <= sat_amp(-(AW+1)'(oi_reg));
                        end
                        MODE_RX:
                        begin
                            nx_reg           <= MW'(UNIT_Q15);
                            nz_reg           <= '0;
                            cordic_start_reg <= 1'b1;
                            state_reg        <= S_CORDIC;
                        end
                        MODE_RY:
                        begin
                            ny_reg           <= MW'(UNIT_Q15);
                            nz_reg           <= '0;
                            cordic_start_reg <= 1'b1;
                            state_reg        <= S_CORDIC;
                        end
                        MODE_RZ:
                        begin
                            cordic_start_reg <= 1'b1;
                            state_reg        <= S_CORDIC;
                        end
                        MODE_AXIS: job_reg <= J_AX2;
                        MODE_MEASURE: job_reg <= J_MEAS;
                        MODE_LOAD: job_reg <= J_N2;
                        default: job_reg <= J_PROB;
                    endcase
                end

                S_MUL:
                begin
                    prod_reg  <= ma * mb;
                    state_reg <= S_ACC;
                end

                S_ACC:
                begin
                    acc_reg <= acc_reg + AW'(prod_reg);
                    if (term_reg == last_term)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        term_reg  <= term_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end

                S_FIN:
                begin
                    term_reg  <= '0;
                    acc_reg   <= '0;
                    grp_reg   <= grp_reg + 2'd1;
                    state_reg <= S_MUL;
                    unique case (job_reg)
                        J_H:   v_reg[grp_reg] <= sat_amp(r16);
                        J_ROT: v_reg[grp_reg] <= sat_amp(r15);
                        J_SN:
                        begin
                            unique case (grp_reg)
                                2'd0:    snx_reg <= r15[MW-1:0];
                                2'd1:    sny_reg <= r15[MW-1:0];
                                default: snz_reg <= r15[MW-1:0];
                            endcase
                        end
                        J_N2, J_AX2: n2_reg <= acc_reg[N2W-1:0];
                        J_MEAS:
                        begin
                            if ($unsigned(acc_reg) > AW'({rf_reg, 14'b0}))
                            begin
                                zr_reg   <= A'(UNIT_Q15);
                                or_reg   <= '0;
                                mbit_reg <= 1'b0;
                            end
                            else
                            begin
                                zr_reg   <= '0;
                                or_reg   <= A'(UNIT_Q15);
                                mbit_reg <= 1'b1;
                            end
                            zi_reg <= '0;
                            oi_reg <= '0;
                        end
                        default:
                        begin
                            if (grp_reg[0])
                                p1_reg <= psat;
                            else
                                p0_reg <= psat;
                        end
                    endcase
                    if (grp_reg == last_grp)
                    begin
                        grp_reg <= '0;
                        unique case (job_reg)
                            J_H, J_ROT: job_reg <= J_N2;
                            J_SN: job_reg <= J_ROT;
                            J_N2:
                            begin
                                div_axis_reg <= 1'b0;
                                state_reg    <= S_NORM_CHK;
                            end
                            J_AX2:
                            begin
                                div_axis_reg <= 1'b1;
                                state_reg    <= S_AX_CHK;
                            end
                            J_MEAS: job_reg <= J_PROB;
                            default: state_reg <= S_OUT;
                        endcase
                    end
                end

                S_NORM_CHK:
                begin
                    if (n2_reg == '0)
                    begin
                        zr_reg    <= A'(UNIT_Q15);
                        zi_reg    <= '0;
                        or_reg    <= '0;
                        oi_reg    <= '0;
                        job_reg   <= J_PROB;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= S_SQRT;
                    end
                end

                S_AX_CHK:
                begin
                    if (n2_reg == '0)
                    begin
                        cordic_start_reg <= 1'b1;
                        state_reg        <= S_CORDIC;
                    end
                    else
                    begin
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= S_SQRT;
                    end
                end

                S_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        grp_reg <= grp_reg + 2'd1;
                        if (div_axis_reg)
                        begin
                            unique case (grp_reg)
                                2'd0:    nx_reg <= quot[MW-1:0];
                                2'd1:    ny_reg <= quot[MW-1:0];
                                default: nz_reg <= quot[MW-1:0];
                            endcase
                            if (grp_reg == 2'd2)
                            begin
                                grp_reg          <= '0;
                                cordic_start_reg <= 1'b1;
                                state_reg        <= S_CORDIC;
                            end
                            else
                            begin
                                div_start_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            unique case (grp_reg)
                                2'd0:    zr_reg <= sat_q(quot);
                                2'd1:    zi_reg <= sat_q(quot);
                                2'd2:    or_reg <= sat_q(quot);
                                default: oi_reg <= sat_q(quot);
                            endcase
                            if (grp_reg == 2'd3)
                            begin
                                grp_reg   <= '0;
                                term_reg  <= '0;
                                acc_reg   <= '0;
                                job_reg   <= J_PROB;
                                state_reg <= S_MUL;
                            end
                            else
                            begin
                                div_start_reg <= 1'b1;
                            end
                        end
                    end
                end

                S_CORDIC:
                begin
                    if (cordic_done)
                    begin
                        grp_reg   <= '0;
                        term_reg  <= '0;
                        acc_reg   <= '0;
                        job_reg   <= J_SN;
                        state_reg <= S_MUL;
                    end
                end

                default:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg   <= 1'b1;
                        zero_re_reg     <= sat16(zr_reg);
                        zero_im_reg     <= sat16(zi_reg);
                        one_re_reg      <= sat16(or_reg);
                        one_im_reg      <= sat16(oi_reg);
                        zero_prob       <= p0_reg;
                        prob_one        <= p1_reg;
                        measured_bit    <= mbit_reg;
                        measure_valid   <= mvalid_reg;
                        state_reg       <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign zero_re   = zero_re_reg;
    assign zero_im   = zero_im_reg;
    assign one_re    = one_re_reg;
    assign one_im    = one_im_reg;

endmodule
